[rtl/ube_pkg.sv]
package ube_pkg;

  localparam int unsigned UBE_QUEUE_DEPTH = 2;
  localparam int unsigned UBE_IDX_W       = 3;

  typedef enum logic [1:0] {
    CLS_SAFE  = 2'd0,
    CLS_AMP   = 2'd1,
    CLS_QUOTE = 2'd2,
    CLS_PCT   = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic       text_end;
  } entry_t;

  localparam logic [7:0] AMP_SEQ   [5] = '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B};
  localparam logic [7:0] QUOTE_SEQ [6] = '{8'h26, 8'h23, 8'h78, 8'h32, 8'h37, 8'h3B};
  localparam logic [7:0] HEX_DIGIT [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [7:0] CHR_PCT = 8'h25;
  localparam logic [7:0] CHR_AMP = 8'h26;
  localparam logic [7:0] CHR_QUO = 8'h27;

  function automatic logic byte_is_safe(input logic [7:0] c);
    logic safe;
    safe = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) safe = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) safe = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) safe = 1'b1;
    case (c)
      8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C,
      8'h25, 8'h23, 8'h40, 8'h3F, 8'h3D, 8'h3B, 8'h3A, 8'h2F, 8'h24: safe = 1'b1;
      default: ;
    endcase
    return safe;
  endfunction

  // index of the final beat of a run
  function automatic logic [UBE_IDX_W-1:0] run_last_idx(input cls_t cls);
    logic [UBE_IDX_W-1:0] r;
    case (cls)
      CLS_SAFE:  r = UBE_IDX_W'(0);
      CLS_AMP:   r = UBE_IDX_W'(4);
      CLS_QUOTE: r = UBE_IDX_W'(5);
      CLS_PCT:   r = UBE_IDX_W'(2);
      default:   r = UBE_IDX_W'(0);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seq_byte(input entry_t e, input logic [UBE_IDX_W-1:0] idx);
    logic [7:0] b;
    b = e.data;
    case (e.cls)
      CLS_SAFE:  b = e.data;
      CLS_AMP:   b = (idx < UBE_IDX_W'(5)) ? AMP_SEQ[idx] : AMP_SEQ[4];
      CLS_QUOTE: b = (idx < UBE_IDX_W'(6)) ? QUOTE_SEQ[idx] : QUOTE_SEQ[5];
      CLS_PCT: begin
        case (idx)
          UBE_IDX_W'(0): b = CHR_PCT;
          UBE_IDX_W'(1): b = HEX_DIGIT[e.data[7:4]];
          default:       b = HEX_DIGIT[e.data[3:0]];
        endcase
      end
      default:   b = e.data;
    endcase
    return b;
  endfunction

endpackage

[rtl/ube_front.sv]
module ube_front (
  input  logic [7:0]      in_byte,
  input  logic            in_text_end,
  output ube_pkg::entry_t entry
);
  import ube_pkg::*;

  cls_t cls;

  always_comb begin
    if (byte_is_safe(in_byte)) begin
      cls = CLS_SAFE;
    end else if (in_byte == CHR_AMP) begin
      cls = CLS_AMP;
    end else if (in_byte == CHR_QUO) begin
      cls = CLS_QUOTE;
    end else begin
      cls = CLS_PCT;
    end
  end

  assign entry = '{data: in_byte, cls: cls, text_end: in_text_end};

endmodule

[rtl/ube_queue.sv]
module ube_queue #(
  parameter int unsigned Depth = ube_pkg::UBE_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ube_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output ube_pkg::entry_t rd_data,
  output logic            empty
);
  import ube_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_wr;
  logic              do_rd;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= ptr_inc(wr_ptr);
      if (do_rd) rd_ptr <= ptr_inc(rd_ptr);
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[rtl/ube_back.sv]
module ube_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ube_pkg::entry_t               head,
  input  logic                          head_valid,
  output logic                          head_done,
  output logic [ube_pkg::UBE_IDX_W-1:0] idx,
  output logic [7:0]                    out_byte,
  output logic                          out_run_last,
  output logic                          out_text_end,
  output logic                          empty,
  input  logic                          pop
);
  import ube_pkg::*;

  logic beat;
  logic at_last;

  assign at_last      = (idx == run_last_idx(head.cls));
  assign beat         = pop && head_valid;
  assign head_done    = beat && at_last;
  assign empty        = !head_valid;
  assign out_byte     = seq_byte(head, idx);
  assign out_run_last = at_last;
  assign out_text_end = at_last && head.text_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat) begin
      idx <= at_last ? '0 : idx + UBE_IDX_W'(1);
    end
  end

endmodule

[rtl/url_href_byte_escaper_top.sv]
// URL escaper for link targets: each text byte becomes one to six bytes.
// Input side is a queue write port: present in_byte/in_text_end with push,
// the beat is taken on a clock edge where push is high and full is low.
// Output side is a queue read port: while empty is low the current result
// beat sits on out_byte/out_run_last/out_text_end; pop takes it.
// Safe bytes give one beat, '&' gives five, the single quote six, and any
// other byte three ('%' and two uppercase hex digits).
// A pushed byte is registered in the queue and comes out in push order.
// Throughput: one input byte per cycle while bytes are safe and pop is
// held; an expanding byte holds the back end for its run length, so the
// output side runs at one beat per cycle and the input side is bounded
// by the total run length of the bytes in flight.
// The classifier and the sequencer are split by a QueueDepth-entry queue;
// full rises only when that queue fills, so input continues while a
// result waits to be popped.
// Reset (rst, synchronous) empties the queue and rewinds the sequencer.
// If pop stays low, results hold and full follows once the queue fills.
module url_href_byte_escaper_top #(
  parameter int unsigned QueueDepth = ube_pkg::UBE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_text_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import ube_pkg::*;

  entry_t                 front_entry;
  entry_t                 head;
  logic                   q_empty;
  logic                   head_done;
  logic [UBE_IDX_W-1:0]   idx;

  ube_front u_front (
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .entry       (front_entry)
  );

  ube_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (head_done),
    .rd_data (head),
    .empty   (q_empty)
  );

  ube_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (!q_empty),
    .head_done    (head_done),
    .idx          (idx),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end),
    .empty        (empty),
    .pop          (pop)
  );

  // mid-run the head entry must still be present
  a_mid_run_head : assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> !q_empty)
    else $error("sequencer mid-run with empty queue");

  a_end_on_last : assert property (@(posedge clk) disable iff (rst)
    (!empty && out_text_end) |-> out_run_last)
    else $error("text end flagged before end of run");

  a_idx_in_run : assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (idx <= run_last_idx(head.cls)))
    else $error("run index beyond run length");

  a_hold_mid_run : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop && idx != '0) |=> (idx == $past(idx)))
    else $error("run index moved without a beat");

endmodule
